// File: rtl/lrupr_pkg.sv
package lrupr_pkg;

  // Fixed field widths of the request and result items
  localparam int PAGE_NUMBER_W = 16;
  localparam int FRAME_INDEX_W = 2;
  localparam int FAULT_COUNT_W = 32;

  // Saturation value of the fault counter
  localparam logic [FAULT_COUNT_W-1:0] FAULT_MAX = {FAULT_COUNT_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic update_table;  // apply the request to the frame table
    logic load_result;   // capture the result into the output register
  } lrupr_cmd_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } lrupr_state_t;

endpackage

// File: rtl/lrupr_req_if.sv
interface lrupr_req_if
  import lrupr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [PAGE_NUMBER_W-1:0] page_number;
  logic                     last_in_sequence;

  modport source (output valid, output page_number, output last_in_sequence, input ready);
  modport sink   (input valid, input page_number, input last_in_sequence, output ready);
endinterface

// File: rtl/lrupr_rsp_if.sv
interface lrupr_rsp_if
  import lrupr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [FRAME_INDEX_W-1:0] frame_index;
  logic [FAULT_COUNT_W-1:0] fault_count;

  modport source (output valid, output hit, output frame_index, output fault_count,
                  input ready);
  modport sink   (input valid, input hit, input frame_index, input fault_count,
                  output ready);
endinterface

// File: rtl/lru_page_replacement.sv
// Channel | Dir | Payload                                  | Handshake
// req     | in  | page_number[15:0], last_in_sequence      | valid/ready
// rsp     | out | hit, frame_index[1:0], fault_count[31:0] | valid/ready
//
// One request per cycle unless the result stalls: all frames are compared, the
// frame is chosen and the ranks updated in the cycle the request is taken; the
// result is registered and shows in the cycle after the request is taken.
// Reset (rst, synchronous) empties all frames and clears the fault count.
// A stalled result holds the output register; a new request is still taken
// in the cycle the held result is drained.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  lrupr_req_if.sink   req,
  lrupr_rsp_if.source rsp
);

  lrupr_cmd_t cmd;

  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  lrupr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .page_number      (req.page_number),
    .last_in_sequence (req.last_in_sequence),
    .hit              (rsp.hit),
    .frame_index      (rsp.frame_index),
    .fault_count      (rsp.fault_count)
  );

endmodule

// File: rtl/lrupr_ctrl.sv
module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output lrupr_cmd_t cmd
);

  lrupr_state_t state, state_next;
  logic         accept;

  // A request is taken when the output register is empty or being drained
  assign req_ready = (state == ST_EMPTY) || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign rsp_valid = (state == ST_FULL);

  assign cmd.update_table = accept;
  assign cmd.load_result  = accept;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_EMPTY: begin
        if (accept) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (!accept && rsp_ready) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/lrupr_datapath.sv
module lrupr_datapath
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lrupr_cmd_t               cmd,
  input  logic [PAGE_NUMBER_W-1:0] page_number,
  input  logic                     last_in_sequence,
  output logic                     hit,
  output logic [FRAME_INDEX_W-1:0] frame_index,
  output logic [FAULT_COUNT_W-1:0] fault_count
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int KEY_W  = (PAGE_BITS < PAGE_NUMBER_W) ? PAGE_BITS : PAGE_NUMBER_W;
  localparam logic [IDX_W:0]   NO_RANK  = (IDX_W+1)'(FRAMES);
  localparam logic [IDX_W-1:0] OLDEST   = IDX_W'(FRAMES - 1);

  // Frame table
  logic [KEY_W-1:0]         frame_page  [FRAMES];
  logic [FRAMES-1:0]        frame_valid;
  logic [IDX_W-1:0]         recency_rank[FRAMES];
  logic [FAULT_COUNT_W-1:0] fault_total;

  logic [KEY_W-1:0]         key;
  logic [FRAMES-1:0]        hit_vec;
  logic                     any_hit;
  logic                     any_empty;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         empty_idx;
  logic [IDX_W-1:0]         victim_idx;
  logic [IDX_W-1:0]         slot;
  logic [IDX_W:0]           old_rank;
  logic [IDX_W-1:0]         rank_next [FRAMES];
  logic [FAULT_COUNT_W-1:0] fault_next;
  logic [IDX_W+1:0]         slot_ext;

  assign key = page_number[KEY_W-1:0];

  // Parallel tag compare
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      hit_vec[i] = frame_valid[i] && (frame_page[i] == key);
    end
  end

  assign any_hit   = |hit_vec;
  assign any_empty = ~&frame_valid;

  // Lowest-numbered matching frame, empty frame and oldest frame
  always_comb begin
    hit_idx    = '0;
    empty_idx  = '0;
    victim_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i])                  hit_idx    = IDX_W'(i);
      if (!frame_valid[i])             empty_idx  = IDX_W'(i);
      if (recency_rank[i] == OLDEST)   victim_idx = IDX_W'(i);
    end
  end

  always_comb begin
    if (any_hit)        slot = hit_idx;
    else if (any_empty) slot = empty_idx;
    else                slot = victim_idx;
  end

  // Recency update: younger valid frames age by one, chosen frame goes to zero
  assign old_rank = frame_valid[slot] ? {1'b0, recency_rank[slot]} : NO_RANK;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (IDX_W'(i) == slot) begin
        rank_next[i] = '0;
      end else if (frame_valid[i] && ({1'b0, recency_rank[i]} < old_rank)) begin
        rank_next[i] = recency_rank[i] + 1'b1;
      end else begin
        rank_next[i] = recency_rank[i];
      end
    end
  end

  // Saturating fault counter
  always_comb begin
    if (any_hit || (fault_total == FAULT_MAX)) fault_next = fault_total;
    else                                       fault_next = fault_total + 1'b1;
  end

  assign slot_ext = {2'b00, slot};

  // Control state of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      fault_total <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (cmd.update_table) begin
      if (last_in_sequence) begin
        frame_valid <= '0;
        fault_total <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          recency_rank[i] <= '0;
        end
      end else begin
        frame_valid[slot] <= 1'b1;
        fault_total       <= fault_next;
        for (int i = 0; i < FRAMES; i++) begin
          recency_rank[i] <= rank_next[i];
        end
      end
    end
  end

  // Page tags, no reset
  always_ff @(posedge clk) begin
    if (cmd.update_table) begin
      frame_page[slot] <= key;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      hit         <= any_hit;
      frame_index <= slot_ext[FRAME_INDEX_W-1:0];
      fault_count <= fault_next;
    end
  end

endmodule
